@@ rtl/dldf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dldf_pkg: shared types and constants of the DSD lookup-table FIR decimator
// Holds field widths, codes, reset values and the queue entry type.
// ----------------------------------------------------------------------------
package dldf_pkg;

  // Parameter defaults.
  localparam int DEF_MAX_BYTE_TAPS = 64;
  localparam int DEF_COEF_WIDTH    = 32;

  // Fixed field widths.
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int ROW_IN_W   = 6;
  localparam int COEF_IN_W  = 32;
  localparam int PCM_W      = 38;
  localparam int GROUP_W    = 6;
  localparam int CLAMP_W    = 9;   // wide enough for the largest tap count
  localparam int ROW_MAX_W  = 8;   // row index of the largest tap count
  localparam int COEF_MAX_W = 48;  // widest stored coefficient

  localparam int QUEUE_DEPTH = 2;

  // Operation codes.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIM  = 2'd1;

  localparam logic [CFG_W-1:0] LENGTH_RESET = 7'd8;
  localparam logic [CFG_W-1:0] DECIM_RESET  = 7'd8;
  localparam logic [CFG_W-1:0] DECIM_MAX    = 7'd64;

  // Idle DSD pattern held by every ring slot after a restart.
  localparam logic [7:0] IDLE_BYTE = 8'h69;

  // One classified beat on its way from the front to the back.
  typedef struct packed {
    logic                         op;
    logic                         emit;
    logic [7:0]                   dsd_byte;
    logic [ROW_MAX_W-1:0]         row;
    logic [7:0]                   col;
    logic signed [COEF_MAX_W-1:0] coef;
  } qent_t;

endpackage

@@ rtl/dldf_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dldf_queue: short FIFO between front and back
// Holds classified beats so that each side can stall on its own.
// ----------------------------------------------------------------------------
module dldf_queue import dldf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  qent_t wr_entry,
  output logic  rd_valid,
  input  logic  rd_pop,
  output qent_t rd_entry
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  qent_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_entry = entries[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/dldf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dldf_front: input classifier
// Accepts beats, counts pushes per decimation group and queues work.
// ----------------------------------------------------------------------------
module dldf_front import dldf_pkg::*; #(
  parameter int MAX_BYTE_TAPS = DEF_MAX_BYTE_TAPS,
  parameter int COEF_WIDTH    = DEF_COEF_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        restart,
  input  logic [CFG_W-1:0]            dec_eff,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        operation,
  input  logic [7:0]                  dsd_byte,
  input  logic [ROW_IN_W-1:0]         table_row,
  input  logic [7:0]                  table_byte,
  input  logic signed [COEF_IN_W-1:0] coefficient,
  output logic                        q_valid,
  input  logic                        q_ready,
  output qent_t                       q_entry
);

  localparam logic [CLAMP_W-1:0] TAPS = CLAMP_W'(MAX_BYTE_TAPS);

  logic [GROUP_W-1:0]          group_count;
  logic [GROUP_W:0]            group_inc;
  logic                        emit;
  logic                        row_ok;
  logic                        accept;
  logic signed [COEF_WIDTH-1:0] coef_fix;

  assign group_inc = {1'b0, group_count} + (GROUP_W + 1)'(1);
  assign emit      = (group_inc >= dec_eff);
  assign row_ok    = (CLAMP_W'(table_row) < TAPS);
  assign coef_fix  = COEF_WIDTH'(coefficient);

  // Loads aimed past the last row are taken and dropped here.
  assign in_ready = q_ready;
  assign q_valid  = in_valid && ((operation == OP_PUSH) || row_ok);
  assign accept   = in_valid && in_ready && (operation == OP_PUSH);

  always_comb begin
    q_entry          = '0;
    q_entry.op       = operation;
    q_entry.emit     = emit;
    q_entry.dsd_byte = dsd_byte;
    q_entry.row      = ROW_MAX_W'(table_row);
    q_entry.col      = table_byte;
    q_entry.coef     = COEF_MAX_W'(coef_fix);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      group_count <= '0;
    end else if (accept) begin
      group_count <= emit ? '0 : group_inc[GROUP_W-1:0];
    end
  end

endmodule

@@ rtl/dldf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dldf_back: ring, coefficient table and window accumulator
// Executes queued beats and sums one table lookup per tap per cycle.
// ----------------------------------------------------------------------------
module dldf_back import dldf_pkg::*; #(
  parameter int MAX_BYTE_TAPS = DEF_MAX_BYTE_TAPS,
  parameter int COEF_WIDTH    = DEF_COEF_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 restart,
  input  logic [$clog2(MAX_BYTE_TAPS+1)-1:0]   len_eff,
  input  logic                                 q_valid,
  output logic                                 q_pop,
  input  qent_t                                q_entry,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [PCM_W-1:0]              pcm_sample
);

  localparam int LEN_W  = $clog2(MAX_BYTE_TAPS + 1);
  localparam int ROW_W  = (MAX_BYTE_TAPS > 1) ? $clog2(MAX_BYTE_TAPS) : 1;
  localparam int TAB_N  = MAX_BYTE_TAPS * 256;
  localparam int TAB_AW = $clog2(TAB_N);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SUM   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]                   state;
  logic [ROW_W-1:0]             wpos;
  logic [LEN_W-1:0]             wpos_inc;
  logic [ROW_W-1:0]             wpos_next;
  logic [ROW_W-1:0]             pos;
  logic [LEN_W-1:0]             pos_inc;
  logic [ROW_W-1:0]             tap;
  logic                         last_tap;

  logic [7:0]                   ring_mem [MAX_BYTE_TAPS];
  logic [MAX_BYTE_TAPS-1:0]     ring_vld;
  logic                         ring_wr;

  logic signed [COEF_WIDTH-1:0] tab_mem [TAB_N];
  logic                         tab_wr;
  logic [TAB_AW-1:0]            tab_waddr;
  logic [TAB_AW-1:0]            tab_raddr;

  // Pipeline: stage 1 holds the ring byte, stage 2 the table word.
  logic                         s1_valid;
  logic [7:0]                   s1_byte;
  logic                         s1_vld;
  logic [ROW_W-1:0]             s1_tap;
  logic [7:0]                   s1_eff;
  logic                         s2_valid;
  logic signed [COEF_WIDTH-1:0] s2_coef;
  logic signed [PCM_W-1:0]      acc;
  logic                         finish;

  assign q_pop     = (state == ST_IDLE) && q_valid;
  assign ring_wr   = q_pop && (q_entry.op == OP_PUSH);
  assign tab_wr    = q_pop && (q_entry.op == OP_LOAD);
  assign tab_waddr = TAB_AW'({ROW_W'(q_entry.row), q_entry.col});

  assign wpos_inc  = LEN_W'(wpos) + LEN_W'(1);
  assign wpos_next = (wpos_inc >= len_eff) ? '0 : wpos_inc[ROW_W-1:0];
  assign pos_inc   = LEN_W'(pos) + LEN_W'(1);
  assign last_tap  = (LEN_W'(tap) + LEN_W'(1) == len_eff);

  assign s1_eff    = s1_vld ? s1_byte : IDLE_BYTE;
  assign tab_raddr = TAB_AW'({s1_tap, s1_eff});

  assign finish = (state == ST_DRAIN) && !s1_valid && !s2_valid
                  && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (ring_wr) begin
      ring_mem[wpos] <= q_entry.dsd_byte;
    end
    s1_byte <= ring_mem[pos];
  end

  always_ff @(posedge clk) begin
    if (tab_wr) begin
      tab_mem[tab_waddr] <= COEF_WIDTH'(q_entry.coef);
    end
    s2_coef <= tab_mem[tab_raddr];
  end

  always_ff @(posedge clk) begin
    s1_vld <= ring_vld[pos];
    s1_tap <= tap;
    if (state == ST_IDLE) begin
      acc <= '0;
    end else if (s2_valid) begin
      acc <= acc + PCM_W'(s2_coef);
    end
    if (finish) begin
      pcm_sample <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wpos      <= '0;
      ring_vld  <= '0;
      pos       <= '0;
      tap       <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= (state == ST_SUM);
      s2_valid <= s1_valid;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (restart) begin
        wpos     <= '0;
        ring_vld <= '0;
      end
      unique case (state)
        ST_IDLE: begin
          if (ring_wr) begin
            ring_vld[wpos] <= 1'b1;
            wpos           <= wpos_next;
            if (q_entry.emit) begin
              // The oldest byte sits where the next push will land.
              pos   <= wpos_next;
              tap   <= '0;
              state <= ST_SUM;
            end
          end
        end
        ST_SUM: begin
          if (last_tap) begin
            state <= ST_DRAIN;
          end else begin
            tap <= tap + ROW_W'(1);
            pos <= (pos_inc >= len_eff) ? '0 : pos_inc[ROW_W-1:0];
          end
        end
        ST_DRAIN: begin
          if (finish) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/dsd_lut_decimating_fir_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_lut_decimating_fir_core: DSD-to-PCM lookup-table FIR decimator
// Pushes DSD bytes into a window ring and, once per decimation group, sums one
// coefficient table lookup per window byte into a 38-bit PCM sample.
// ----------------------------------------------------------------------------
// Flow: a push that closes a group starts a window sum; the back end then reads
//   one tap per cycle from the table port and pops no queued beat until the
//   sum is done and the previous sample has been taken.
// Reset: rst (synchronous) sets both registers to 8, clears the group count,
//   write position and ring valid bits; the coefficient table is not cleared.
// ----------------------------------------------------------------------------
module dsd_lut_decimating_fir_core import dldf_pkg::*; #(
  parameter int MAX_BYTE_TAPS = DEF_MAX_BYTE_TAPS,
  parameter int COEF_WIDTH    = DEF_COEF_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration write channel.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  // Input channel.
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        operation,
  input  logic [7:0]                  dsd_byte,
  input  logic [ROW_IN_W-1:0]         table_row,
  input  logic [7:0]                  table_byte,
  input  logic signed [COEF_IN_W-1:0] coefficient,
  // Result channel.
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [PCM_W-1:0]     pcm_sample
);

  localparam int LEN_W = $clog2(MAX_BYTE_TAPS + 1);
  localparam logic [CLAMP_W-1:0] TAPS = CLAMP_W'(MAX_BYTE_TAPS);

  logic [CFG_W-1:0]   length_bytes;
  logic [CFG_W-1:0]   decimation_bytes;
  logic               cfg_wr;
  logic               restart;
  logic [CLAMP_W-1:0] len_wide;
  logic [LEN_W-1:0]   len_eff;
  logic [CFG_W-1:0]   dec_eff;

  logic               q_wr_valid;
  logic               q_wr_ready;
  qent_t              q_wr_entry;
  logic               q_rd_valid;
  logic               q_rd_pop;
  qent_t              q_rd_entry;

  // Register writes are always taken; a write to either register restarts
  // the filter, which clears the ring back to idle DSD and the group count.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign restart   = cfg_wr && ((cfg_index == CFG_LENGTH) || (cfg_index == CFG_DECIM));

  always_ff @(posedge clk) begin
    if (rst) begin
      length_bytes     <= LENGTH_RESET;
      decimation_bytes <= DECIM_RESET;
    end else if (cfg_wr) begin
      if (cfg_index == CFG_LENGTH) begin
        length_bytes <= cfg_data;
      end else if (cfg_index == CFG_DECIM) begin
        decimation_bytes <= cfg_data;
      end
    end
  end

  // Effective values: zero acts as one, and each is capped at its maximum.
  always_comb begin
    if (length_bytes == '0) begin
      len_wide = CLAMP_W'(1);
    end else if (CLAMP_W'(length_bytes) > TAPS) begin
      len_wide = TAPS;
    end else begin
      len_wide = CLAMP_W'(length_bytes);
    end
    len_eff = LEN_W'(len_wide);

    if (decimation_bytes == '0) begin
      dec_eff = CFG_W'(1);
    end else if (decimation_bytes > DECIM_MAX) begin
      dec_eff = DECIM_MAX;
    end else begin
      dec_eff = decimation_bytes;
    end
  end

  // The front classifies each beat and counts the decimation group.
  dldf_front #(
    .MAX_BYTE_TAPS (MAX_BYTE_TAPS),
    .COEF_WIDTH    (COEF_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .restart     (restart),
    .dec_eff     (dec_eff),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .dsd_byte    (dsd_byte),
    .table_row   (table_row),
    .table_byte  (table_byte),
    .coefficient (coefficient),
    .q_valid     (q_wr_valid),
    .q_ready     (q_wr_ready),
    .q_entry     (q_wr_entry)
  );

  // Work queue; lets input keep flowing during a window sum until it is full.
  dldf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_entry (q_wr_entry),
    .rd_valid (q_rd_valid),
    .rd_pop   (q_rd_pop),
    .rd_entry (q_rd_entry)
  );

  // The back owns the ring, the table memory and the accumulator, and holds
  // a finished sample in its output register until it is taken.
  dldf_back #(
    .MAX_BYTE_TAPS (MAX_BYTE_TAPS),
    .COEF_WIDTH    (COEF_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .restart    (restart),
    .len_eff    (len_eff),
    .q_valid    (q_rd_valid),
    .q_pop      (q_rd_pop),
    .q_entry    (q_rd_entry),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pcm_sample (pcm_sample)
  );

endmodule
